>>> hdl/euler_attitude_vector_rotation_assert.svh
// Assertion macros for the Euler attitude vector rotation block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef EULER_ATTITUDE_VECTOR_ROTATION_ASSERT_SVH
`define EULER_ATTITUDE_VECTOR_ROTATION_ASSERT_SVH
`ifndef SYNTHESIS
`define EAVR_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("eavr: forbidden condition seen");
`define EAVR_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("eavr: implication failed");
`else
`define EAVR_ASSERT_NEVER(lbl, clk, rstn, cond)
`define EAVR_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> hdl/eavr_pkg.sv
// Package for the Euler attitude vector rotation block: request, result and
// queue entry types, fixed-point widths, CORDIC constants and rounding helpers.
`default_nettype none
package eavr_pkg;

  localparam int PH_W      = 33;   // folded phase, full turn is 2^32
  localparam int CX_W      = 34;   // CORDIC x/y datapath
  localparam int Q_W       = 32;   // Q2.30 trig and matrix values
  localparam int MAX_STEPS = 24;
  localparam int DEF_STEPS = 16;
  localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [31:0] beam_x;
    logic signed [31:0] beam_y;
    logic signed [31:0] beam_z;
    logic               last_beam;
  } req_t;

  typedef struct packed {
    logic signed [31:0] map_x;
    logic signed [31:0] map_y;
    logic signed [31:0] map_z;
    logic               last_out;
  } res_t;

  typedef struct packed {
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic               last;
  } beam_t;

  // Lane 0 is roll, lane 1 pitch, lane 2 yaw.
  typedef struct packed {
    logic [2:0][PH_W-1:0] phase;
    logic [2:0]           flip;
    beam_t                beam;
  } qent_t;

  typedef struct packed {
    logic [2:0][Q_W-1:0] c;
    logic [2:0][Q_W-1:0] s;
    beam_t               beam;
  } trig_t;

  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

  function automatic logic signed [PH_W-1:0] atan_turn(input int i);
    logic signed [PH_W-1:0] a;
    case (i)
      0: a = 33'sd536870912;   1: a = 33'sd316933406;
      2: a = 33'sd167458907;   3: a = 33'sd85004756;
      4: a = 33'sd42667331;    5: a = 33'sd21354465;
      6: a = 33'sd10679838;    7: a = 33'sd5340245;
      8: a = 33'sd2670163;     9: a = 33'sd1335087;
      10: a = 33'sd667544;     11: a = 33'sd333772;
      12: a = 33'sd166886;     13: a = 33'sd83443;
      14: a = 33'sd41722;      15: a = 33'sd20861;
      16: a = 33'sd10430;      17: a = 33'sd5215;
      18: a = 33'sd2608;       19: a = 33'sd1304;
      20: a = 33'sd652;        21: a = 33'sd326;
      22: a = 33'sd163;        23: a = 33'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Round a Q60 sum to Q30 (add one half, floor shift), result known to fit.
  function automatic logic signed [Q_W-1:0] rnd30(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + 66'sd536870912;
    return t[61:30];
  endfunction

  // Round a Q46 sum to Q16.16 and saturate to 32 bits.
  function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] v);
    logic signed [65:0] t;
    logic signed [35:0] q;
    t = v + 66'sd536870912;
    q = t[65:30];
    if (q > 36'sd2147483647) return 32'sh7fffffff;
    else if (q < -36'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  function automatic logic signed [65:0] sx(input logic signed [63:0] p);
    return {{2{p[63]}}, p};
  endfunction

endpackage
`default_nettype wire

>>> hdl/eavr_front.sv
// Front end: takes requests, folds each angle into the CORDIC range and marks
// the fold. Depends on eavr_pkg.
`default_nettype none
module eavr_front (
  input  wire logic          start_i,
  input  wire eavr_pkg::req_t req_i,
  input  wire logic          full_i,
  output logic               busy_o,
  output eavr_pkg::qctl_t    ctl_o,
  output eavr_pkg::qent_t    ent_o
);
  import eavr_pkg::*;

  logic signed [15:0] ang [3];

  assign ang[0] = req_i.roll_angle;
  assign ang[1] = req_i.pitch_angle;
  assign ang[2] = req_i.yaw_angle;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      logic signed [PH_W-1:0] z;
      z = {ang[j][15], ang[j], 16'd0};
      ent_o.flip[j] = 1'b0;
      if (z > 33'sd1073741824) begin
        z = z - 33'sd2147483648;
        ent_o.flip[j] = 1'b1;
      end else if (z < -33'sd1073741824) begin
        z = z + 33'sd2147483648;
        ent_o.flip[j] = 1'b1;
      end
      ent_o.phase[j] = z;
    end
    ent_o.beam.bx   = req_i.beam_x;
    ent_o.beam.by   = req_i.beam_y;
    ent_o.beam.bz   = req_i.beam_z;
    ent_o.beam.last = req_i.last_beam;
  end

  assign busy_o     = full_i;
  assign ctl_o.full = full_i;
  assign ctl_o.push = start_i && !full_i;

endmodule
`default_nettype wire

>>> hdl/eavr_queue.sv
// Two-entry queue between front end and CORDIC back end.
// Depends on eavr_pkg and the assertion macro header.
`default_nettype none
`include "euler_attitude_vector_rotation_assert.svh"
module eavr_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire eavr_pkg::qent_t ent_i,
  input  wire logic            pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output eavr_pkg::qent_t      ent_o
);
  import eavr_pkg::*;

  qent_t      mem [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign ent_o   = mem[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `EAVR_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o && !do_pop)
  `EAVR_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q == 2'd3)
  `EAVR_ASSERT_IMPLIES(a_ptr_match, clk_i, rst_ni, cnt_q == 2'd0 || cnt_q == 2'd2,
                       wr_q == rd_q)
endmodule
`default_nettype wire

>>> hdl/eavr_cordic.sv
// Pipelined rotation-mode CORDIC, three angle lanes side by side, one
// micro-rotation per stage. Depends on eavr_pkg.
`default_nettype none
module eavr_cordic #(
  parameter int CORDIC_STEPS = eavr_pkg::DEF_STEPS
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire eavr_pkg::qent_t ent_i,
  output logic                 valid_o,
  output eavr_pkg::trig_t      trig_o
);
  import eavr_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

  logic signed [CX_W-1:0] x_q [1:NSTEP][3];
  logic signed [CX_W-1:0] y_q [1:NSTEP][3];
  logic signed [PH_W-1:0] z_q [1:NSTEP][3];
  logic [2:0]             flip_q [1:NSTEP];
  beam_t                  beam_q [1:NSTEP];
  logic [NSTEP:1]         v_q;

  for (genvar i = 0; i < NSTEP; i++) begin : g_stage
    localparam logic signed [PH_W-1:0] ATAN = atan_turn(i);

    logic signed [CX_W-1:0] x_c [3];
    logic signed [CX_W-1:0] y_c [3];
    logic signed [PH_W-1:0] z_c [3];
    logic [2:0]             flip_c;
    beam_t                  beam_c;
    logic                   v_c;

    // Stage zero works straight on the queue head.
    if (i == 0) begin : g_head
      always_comb begin
        for (int j = 0; j < 3; j++) begin
          x_c[j] = CORDIC_GAIN;
          y_c[j] = '0;
          z_c[j] = ent_i.phase[j];
        end
        flip_c = ent_i.flip;
        beam_c = ent_i.beam;
        v_c    = valid_i;
      end
    end else begin : g_body
      always_comb begin
        for (int j = 0; j < 3; j++) begin
          x_c[j] = x_q[i][j];
          y_c[j] = y_q[i][j];
          z_c[j] = z_q[i][j];
        end
        flip_c = flip_q[i];
        beam_c = beam_q[i];
        v_c    = v_q[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_c;
      end
    end

    always_ff @(posedge clk_i) begin
      for (int j = 0; j < 3; j++) begin
        if (!z_c[j][PH_W-1]) begin
          x_q[i+1][j] <= x_c[j] - (y_c[j] >>> i);
          y_q[i+1][j] <= y_c[j] + (x_c[j] >>> i);
          z_q[i+1][j] <= z_c[j] - ATAN;
        end else begin
          x_q[i+1][j] <= x_c[j] + (y_c[j] >>> i);
          y_q[i+1][j] <= y_c[j] - (x_c[j] >>> i);
          z_q[i+1][j] <= z_c[j] + ATAN;
        end
      end
      flip_q[i+1] <= flip_c;
      beam_q[i+1] <= beam_c;
    end
  end

  // Undo the quadrant fold and hand the trig values on in Q2.30.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v_q[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      trig_o.c[j] <= flip_q[NSTEP][j] ? Q_W'(-x_q[NSTEP][j]) : Q_W'(x_q[NSTEP][j]);
      trig_o.s[j] <= flip_q[NSTEP][j] ? Q_W'(-y_q[NSTEP][j]) : Q_W'(y_q[NSTEP][j]);
    end
    trig_o.beam <= beam_q[NSTEP];
  end
endmodule
`default_nettype wire

>>> hdl/eavr_matrix.sv
// Builds the ZYX direction cosine matrix from the trig values and applies its
// transpose to the beam vector, with round and saturate. Depends on eavr_pkg.
`default_nettype none
module eavr_matrix (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire eavr_pkg::trig_t trig_i,
  output logic                 valid_o,
  output eavr_pkg::res_t       res_o
);
  import eavr_pkg::*;

  logic [5:0] v_q;
  beam_t      b1_q, b2_q, b3_q, b4_q, b5_q, b6_q;

  logic signed [Q_W-1:0] cphi, sphi, cth, sth, cpsi, spsi;
  assign cphi = trig_i.c[0];
  assign sphi = trig_i.s[0];
  assign cth  = trig_i.c[1];
  assign sth  = trig_i.s[1];
  assign cpsi = trig_i.c[2];
  assign spsi = trig_i.s[2];

  // Stage 1 products.
  logic signed [63:0]    p_stsp_q, p_stcp_q, p11_q, p12_q, p23_q, p33_q;
  logic signed [Q_W-1:0] cphi1_q, sphi1_q, cpsi1_q, spsi1_q, sth1_q;
  // Stage 2 rounded terms.
  logic signed [Q_W-1:0] stsp_q, stcp_q, r11_q, r12_q, r13_q, r23_q, r33_q;
  logic signed [Q_W-1:0] cphi2_q, sphi2_q, cpsi2_q, spsi2_q;
  // Stage 3 products.
  logic signed [63:0]    qa_q, qb_q, qc_q, qd_q, qe_q, qf_q, qg_q, qh_q;
  logic signed [Q_W-1:0] r11b_q, r12b_q, r13b_q, r23b_q, r33b_q;
  // Stage 4 full matrix.
  logic signed [Q_W-1:0] m11_q, m12_q, m13_q, m21_q, m22_q, m23_q, m31_q, m32_q, m33_q;
  // Stage 5 vector products.
  logic signed [63:0]    t11_q, t21_q, t31_q, t12_q, t22_q, t32_q, t13_q, t23_q, t33_q;
  // Stage 6 sums.
  logic signed [65:0]    sx_q, sy_q, sz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      valid_o <= 1'b0;
    end else begin
      v_q     <= {v_q[4:0], valid_i};
      valid_o <= v_q[5];
    end
  end

  always_ff @(posedge clk_i) begin
    p_stsp_q <= sth * sphi;
    p_stcp_q <= sth * cphi;
    p11_q    <= cpsi * cth;
    p12_q    <= spsi * cth;
    p23_q    <= cth * sphi;
    p33_q    <= cth * cphi;
    cphi1_q  <= cphi;
    sphi1_q  <= sphi;
    cpsi1_q  <= cpsi;
    spsi1_q  <= spsi;
    sth1_q   <= sth;
    b1_q     <= trig_i.beam;

    stsp_q  <= rnd30(sx(p_stsp_q));
    stcp_q  <= rnd30(sx(p_stcp_q));
    r11_q   <= rnd30(sx(p11_q));
    r12_q   <= rnd30(sx(p12_q));
    r23_q   <= rnd30(sx(p23_q));
    r33_q   <= rnd30(sx(p33_q));
    r13_q   <= -sth1_q;
    cphi2_q <= cphi1_q;
    sphi2_q <= sphi1_q;
    cpsi2_q <= cpsi1_q;
    spsi2_q <= spsi1_q;
    b2_q    <= b1_q;

    qa_q   <= spsi2_q * cphi2_q;
    qb_q   <= cpsi2_q * stsp_q;
    qc_q   <= cpsi2_q * cphi2_q;
    qd_q   <= spsi2_q * stsp_q;
    qe_q   <= spsi2_q * sphi2_q;
    qf_q   <= cpsi2_q * stcp_q;
    qg_q   <= cpsi2_q * sphi2_q;
    qh_q   <= spsi2_q * stcp_q;
    r11b_q <= r11_q;
    r12b_q <= r12_q;
    r13b_q <= r13_q;
    r23b_q <= r23_q;
    r33b_q <= r33_q;
    b3_q   <= b2_q;

    m21_q <= rnd30(sx(qb_q) - sx(qa_q));
    m22_q <= rnd30(sx(qc_q) + sx(qd_q));
    m31_q <= rnd30(sx(qe_q) + sx(qf_q));
    m32_q <= rnd30(sx(qh_q) - sx(qg_q));
    m11_q <= r11b_q;
    m12_q <= r12b_q;
    m13_q <= r13b_q;
    m23_q <= r23b_q;
    m33_q <= r33b_q;
    b4_q  <= b3_q;

    t11_q <= m11_q * b4_q.bx;
    t21_q <= m21_q * b4_q.by;
    t31_q <= m31_q * b4_q.bz;
    t12_q <= m12_q * b4_q.bx;
    t22_q <= m22_q * b4_q.by;
    t32_q <= m32_q * b4_q.bz;
    t13_q <= m13_q * b4_q.bx;
    t23_q <= m23_q * b4_q.by;
    t33_q <= m33_q * b4_q.bz;
    b5_q  <= b4_q;

    sx_q <= sx(t11_q) + sx(t21_q) + sx(t31_q);
    sy_q <= sx(t12_q) + sx(t22_q) + sx(t32_q);
    sz_q <= sx(t13_q) + sx(t23_q) + sx(t33_q);
    b6_q <= b5_q;

    res_o.map_x    <= rnd_sat(sx_q);
    res_o.map_y    <= rnd_sat(sy_q);
    res_o.map_z    <= rnd_sat(sz_q);
    res_o.last_out <= b6_q.last;
  end
endmodule
`default_nettype wire

>>> hdl/euler_attitude_vector_rotation.sv
// Top level of the Euler ZYX attitude rotation block: front end, queue,
// CORDIC and matrix back end. Depends on eavr_pkg and the eavr_* modules.
//
// Usage: a request (three 16-bit binary angles, a Q16.16 beam vector and a
// last-beam flag) is taken at a rising edge where start is high and busy is
// low. The block returns the vector rotated into north/east/down map axes,
// saturated to 32 bits, with the flag copied through.
// Each result appears on res_o for exactly one cycle, marked by res_valid_o.
// The receiver cannot stall the block, and it does not need to: the back end
// advances every cycle, so the two-entry queue drains as fast as it fills and
// busy stays low in normal operation.
// Throughput is one request per cycle while busy is low. From the accepting
// edge a request passes through the queue, one CORDIC micro-rotation stage
// per step, a register that undoes the quadrant fold and the matrix and
// vector multiply pipeline before its result is taken.
// Reset (rst_ni low, asynchronous) empties the queue and clears all valid
// bits; requests in flight are dropped. The block keeps no state between
// requests.
`default_nettype none
module euler_attitude_vector_rotation #(
  parameter int CORDIC_STEPS = eavr_pkg::DEF_STEPS
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire eavr_pkg::req_t req_i,
  output logic                res_valid_o,
  output eavr_pkg::res_t      res_o
);
  import eavr_pkg::*;

  qctl_t qctl;
  qent_t front_ent, head_ent;
  logic  q_full, head_valid, trig_valid;
  trig_t trig;

  // Front end: fold the angles and push into the queue.
  eavr_front u_front (
    .start_i (start),
    .req_i   (req_i),
    .full_i  (q_full),
    .busy_o  (busy),
    .ctl_o   (qctl),
    .ent_o   (front_ent)
  );

  eavr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (qctl.push),
    .ent_i   (front_ent),
    .pop_i   (1'b1),
    .full_o  (q_full),
    .valid_o (head_valid),
    .ent_o   (head_ent)
  );

  // Back end: the CORDIC pipeline pops the queue head every cycle.
  eavr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_valid),
    .ent_i   (head_ent),
    .valid_o (trig_valid),
    .trig_o  (trig)
  );

  eavr_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (trig_valid),
    .trig_i  (trig),
    .valid_o (res_valid_o),
    .res_o   (res_o)
  );
endmodule
`default_nettype wire

>>> bench/tb_top.sv
// Testbench for euler_attitude_vector_rotation: random and directed beam requests
// checked against a bit-exact CORDIC and rotation predictor. Depends on eavr_pkg.
`default_nettype none
module tb_top;
  import eavr_pkg::*;

  localparam int STEPS   = 16;
  localparam int LATENCY = STEPS + 9;
  localparam int N_RAND  = 1700;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic res_valid_o;
  res_t res_o;

  req_t pending_reqs[$];
  res_t expected_maps[$];
  int   n_errors = 0;
  bit   stim_done = 1'b0;
  bit   calm = 1'b0;    // no idling in the last part of the run
  int   idle_left = 0;

  always #5 clk_i = ~clk_i;

  euler_attitude_vector_rotation #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .res_valid_o(res_valid_o), .res_o(res_o)
  );

  // Arctangent of 2^-i in phase units, where a full turn is 2^32.
  function automatic longint atan_phase(input int i);
    longint tbl[24];
    tbl = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215,
            2608, 1304, 652, 326, 163, 81};
    return tbl[i];
  endfunction

  // Rounding of a Q60 value to Q30 (add one half, floor shift); >>> on longint is arithmetic.
  function automatic longint round30(input longint v);
    return (v + (longint'(1) << 29)) >>> 30;
  endfunction

  // Sine and cosine of a binary angle, Q2.30, with the quadrant fold.
  task automatic angle_trig(input logic signed [15:0] ang, output longint c,
                            output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    int n;
    z = longint'(ang) * 65536;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    n = (STEPS > 24) ? 24 : STEPS;
    if (z > (longint'(1) << 30)) begin
      z -= longint'(1) << 31;
      flip = 1'b1;
    end else if (z < -(longint'(1) << 30)) begin
      z += longint'(1) << 31;
      flip = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_phase(i);
      end else begin
        x += dx; y -= dy; z += atan_phase(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Map-frame vector for one beam: R transposed times the vehicle vector.
  // Products of Q30 by Q16.16 stay within 62 bits, and three of them in 64.
  task automatic rotate_to_map(input req_t r, output res_t m);
    longint cf, sf, ct, st, cs, ss, stsf, stcf;
    longint r11, r12, r13, r21, r22, r23, r31, r32, r33, bx, by, bz;
    angle_trig(r.roll_angle, cf, sf);
    angle_trig(r.pitch_angle, ct, st);
    angle_trig(r.yaw_angle, cs, ss);
    bx = r.beam_x; by = r.beam_y; bz = r.beam_z;
    stsf = round30(st * sf);
    stcf = round30(st * cf);
    r11 = round30(cs * ct);
    r12 = round30(ss * ct);
    r13 = -st;
    r21 = round30(-(ss * cf) + cs * stsf);
    r22 = round30(cs * cf + ss * stsf);
    r23 = round30(ct * sf);
    r31 = round30(ss * sf + cs * stcf);
    r32 = round30(-(cs * sf) + ss * stcf);
    r33 = round30(ct * cf);
    m.map_x = clamp32(round30(r11 * bx + r21 * by + r31 * bz));
    m.map_y = clamp32(round30(r12 * bx + r22 * by + r32 * bz));
    m.map_z = clamp32(round30(r13 * bx + r23 * by + r33 * bz));
    m.last_out = r.last_beam;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
    n_errors++;
  endtask

  function automatic req_t rand_beam();
    req_t r;
    logic [15:0] special[4];
    special = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000};
    r.roll_angle  = ($urandom_range(0, 7) == 0) ? special[$urandom_range(0, 3)]
                                                : 16'($urandom);
    r.pitch_angle = ($urandom_range(0, 7) == 0) ? special[$urandom_range(0, 3)]
                                                : 16'($urandom);
    r.yaw_angle   = ($urandom_range(0, 7) == 0) ? special[$urandom_range(0, 3)]
                                                : 16'($urandom);
    // Mostly realistic ranges, sometimes full-scale values that saturate.
    if ($urandom_range(0, 3) == 0) begin
      r.beam_x = $urandom; r.beam_y = $urandom; r.beam_z = $urandom;
    end else begin
      r.beam_x = 32'($signed(24'($urandom)));
      r.beam_y = 32'($signed(24'($urandom)));
      r.beam_z = 32'($signed(24'($urandom)));
    end
    r.last_beam = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Directed requests: extreme angles and vectors, the -pi case, and
  // saturating full-scale vectors; then the random stream.
  initial begin
    req_t r;
    logic signed [15:0] angs[5];
    logic signed [31:0] vecs[4];
    angs = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh4000, -16'sh4000};
    vecs = '{32'sh80000000, 32'sh7fffffff, 32'sh00010000, 32'sh00000000};
    for (int k = 0; k < 20; k++) begin
      r.roll_angle  = angs[k % 5];
      r.pitch_angle = angs[(k / 5) % 5];
      r.yaw_angle   = angs[(k * 3) % 5];
      r.beam_x = vecs[k % 4];
      r.beam_y = vecs[(k + 1) % 4];
      r.beam_z = vecs[(k / 4) % 4];
      r.last_beam = k[0];
      pending_reqs.push_back(r);
    end
    for (int k = 0; k < N_RAND; k++) pending_reqs.push_back(rand_beam());
  end

  // Driver: a request stays on the port until an edge takes it; random bursts
  // of idle cycles come between requests until the last part of the run.
  always @(posedge clk_i) begin
    res_t m;
    if (rst_ni) begin
      if (start && !busy) begin
        rotate_to_map(req_i, m);
        expected_maps.push_back(m);
        void'(pending_reqs.pop_front());
      end
      calm <= (pending_reqs.size() < 200);
      if (!(start && busy)) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          if (!calm && $urandom_range(0, 9) == 0) begin
            idle_left <= $urandom_range(0, 5);
            start <= 1'b0;
          end else begin
            start <= 1'b1;
            req_i <= pending_reqs[0];
          end
        end else begin
          start <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // Monitor: every strobed result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (expected_maps.size() == 0) begin
        report_mismatch("unexpected result map_x", res_o.map_x, 32'h0);
      end else begin
        want = expected_maps.pop_front();
        if (res_o.map_x !== want.map_x) report_mismatch("map_x", res_o.map_x, want.map_x);
        if (res_o.map_y !== want.map_y) report_mismatch("map_y", res_o.map_y, want.map_y);
        if (res_o.map_z !== want.map_z) report_mismatch("map_z", res_o.map_z, want.map_z);
        if (res_o.last_out !== want.last_out)
          report_mismatch("last_out", 32'(res_o.last_out), 32'(want.last_out));
      end
    end
  end

  // Reset once, wait for the stream to drain, then let the pipeline run on before the final check.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && expected_maps.size() == 0);
    repeat (LATENCY + 5) @(posedge clk_i);
    if (n_errors == 0 && expected_maps.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #500000;
    $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
